>>> hdl/panel_status_frame_builder_defines.svh
// ----------------------------------------------------------------------------
// panel_status_frame_builder_defines
// Assertion macros used by the checker file psfb_checker. Each expects i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PANEL_STATUS_FRAME_BUILDER_DEFINES_SVH
`define PANEL_STATUS_FRAME_BUILDER_DEFINES_SVH

// Plain clocked property, off while reset is held.
`define PSFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same-cycle implication.
`define PSFB_ASSERT_IMPL(label, ante, cons, msg) \
    `PSFB_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PSFB_ASSERT_NEXT(label, ante, cons, msg) \
    `PSFB_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> hdl/psfb_pkg.sv
// ----------------------------------------------------------------------------
// psfb_pkg
// Widths, register indexes, reset values and frame layout of the status frame
// builder.
// ----------------------------------------------------------------------------
package psfb_pkg;

    localparam int FRAME_BITS = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int PERIOD_W   = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_COUNT     = 3'd0,
        CFG_HEAT_ON_THRESHOLD  = 3'd1,
        CFG_HEAT_OFF_THRESHOLD = 3'd2,
        CFG_DAY_GAIN           = 3'd3,
        CFG_LINK_TIMEOUT       = 3'd4,
        CFG_STARTUP_DELAY      = 3'd5
    } t_cfg_idx;

    localparam logic [7:0]          RST_DEBOUNCE_COUNT = 8'd245;
    localparam logic [7:0]          RST_HEAT_ON        = 8'd123;
    localparam logic [7:0]          RST_HEAT_OFF       = 8'd135;
    localparam logic [7:0]          RST_DAY_GAIN       = 8'd0;
    localparam logic [7:0]          RST_LINK_TIMEOUT   = 8'd255;
    localparam logic [PERIOD_W-1:0] RST_STARTUP_DELAY  = 14'd12500;

    localparam logic [7:0]          LINK_TIMED_OUT = 8'hFF;
    localparam logic [PERIOD_W-1:0] DAY_OFFSET     = 14'd64;
    localparam int                  DAY_MODE_BIT   = 6;

    // Frame layout
    localparam int BTN_LSB    = 8;
    localparam int TEMP_MSB_AT = 12;
    localparam int HEAT_BIT   = 20;
    localparam int HOK_BIT    = 29;
    localparam int PARITY_BIT = 31;

    // Bits that never vary (everything but buttons, temp, heater, ok, parity)
    localparam logic [FRAME_BITS-1:0] FRAME_FIXED_MASK  = 32'h5FE0_00FF;
    localparam logic [FRAME_BITS-1:0] FRAME_FIXED_VALUE = 32'h4020_0001;

endpackage

>>> hdl/panel_status_frame_builder.sv
// ----------------------------------------------------------------------------
// panel_status_frame_builder
// One control-loop pass per transfer: button and temperature debounce, heater
// hysteresis, 32-bit odd-parity status frame, link byte timeout and PWM period.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    button_pins .. rx_good
//  result    out        o_valid / i_stall    status_frame, pwm_period, period_changed
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One item per cycle while i_stall is low; each passes the input register, then the result register.
// The pass logic (compares, one 6x8 multiply, frame packing) sits between them.
// A held result stalls the result register; the input register still fills,
// so o_stall rises only when both are full and i_stall is high.
// Synchronous active-low reset loads the register defaults and clears the pass state and valid flags.
// ----------------------------------------------------------------------------
module panel_status_frame_builder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config
    input  logic                                i_cfg_we,
    input  logic [psfb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psfb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [3:0]                          i_button_pins,
    input  logic                                i_heater_ok,
    input  logic [7:0]                          i_adc_sample,
    input  logic                                i_rx_present,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_rx_good,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [psfb_pkg::FRAME_BITS-1:0]     o_status_frame,
    output logic [psfb_pkg::PERIOD_W-1:0]       o_pwm_period,
    output logic                                o_period_changed
);
    import psfb_pkg::*;

    // config registers
    logic [7:0]          r_cfg_debounce;
    logic [7:0]          r_cfg_heat_on;
    logic [7:0]          r_cfg_heat_off;
    logic [7:0]          r_cfg_day_gain;
    logic [7:0]          r_cfg_link_timeout;
    logic [PERIOD_W-1:0] r_cfg_startup_delay;

    // input register
    logic       r_in_valid;
    logic [3:0] r_in_pins;
    logic       r_in_hok;
    logic [7:0] r_in_sample;
    logic       r_in_rx_present;
    logic [7:0] r_in_rx_byte;
    logic       r_in_rx_good;

    // pass state
    logic [3:0]          r_btn_cand, r_btn_latched;
    logic [7:0]          r_btn_run;
    logic [7:0]          r_temp_cand, r_temp_run, r_temp_latched;
    logic                r_heat_off;
    logic [7:0]          r_link_value, r_link_idle, r_applied;
    logic [PERIOD_W-1:0] r_startup_cnt, r_period;

    // result register
    logic                  r_out_valid;
    logic [FRAME_BITS-1:0] r_out_frame;
    logic                  r_out_changed;

    logic [3:0]            n_btn_cand, n_btn_latched;
    logic [7:0]            n_btn_run;
    logic [7:0]            n_temp_cand, n_temp_run, n_temp_latched;
    logic                  n_heat_off;
    logic [7:0]            n_link_value, n_link_idle, n_applied;
    logic [PERIOD_W-1:0]   n_startup_cnt, n_period;
    logic                  n_changed;
    logic [FRAME_BITS-1:0] n_frame;
    logic [7:0]            btn_run_inc, temp_run_inc, link_idle_inc;
    logic [PERIOD_W-1:0]   day_period;

    logic advance;
    logic in_accept;
    logic process;

    assign advance   = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;
    assign process   = r_in_valid && advance;

    // ---------------- pass logic ----------------
    assign btn_run_inc   = r_btn_run + 8'd1;
    assign temp_run_inc  = r_temp_run + 8'd1;
    assign link_idle_inc = r_link_idle + 8'd1;

    always_comb begin
        n_btn_cand    = r_btn_cand;
        n_btn_run     = r_btn_run;
        n_btn_latched = r_btn_latched;
        if (r_in_pins == r_btn_cand) begin
            n_btn_run = btn_run_inc;
            if (btn_run_inc == r_cfg_debounce) begin
                n_btn_latched = ~r_btn_cand;
                n_btn_run     = 8'd0;
            end
        end else begin
            n_btn_run  = 8'd0;
            n_btn_cand = r_in_pins;
        end

        n_temp_cand    = r_temp_cand;
        n_temp_run     = r_temp_run;
        n_temp_latched = r_temp_latched;
        if (r_in_sample == r_temp_cand) begin
            n_temp_run = temp_run_inc;
            if (temp_run_inc == r_cfg_debounce) begin
                n_temp_latched = r_temp_cand;
                n_temp_run     = 8'd0;
            end
        end else begin
            n_temp_run  = 8'd0;
            n_temp_cand = r_in_sample;
        end

        // clearing wins when thresholds overlap
        n_heat_off = r_heat_off;
        if (n_temp_cand <= r_cfg_heat_on) begin
            n_heat_off = 1'b0;
        end else if (n_temp_cand >= r_cfg_heat_off) begin
            n_heat_off = 1'b1;
        end
    end

    always_comb begin
        n_frame = FRAME_FIXED_VALUE;
        n_frame[BTN_LSB +: 4] = n_btn_latched;
        // temperature goes out MSB first
        for (int k = 0; k < 8; k++) begin
            n_frame[TEMP_MSB_AT + 7 - k] = n_temp_latched[k];
        end
        n_frame[HEAT_BIT]   = n_heat_off;
        n_frame[HOK_BIT]    = r_in_hok;
        n_frame[PARITY_BIT] = ~(^n_frame[PARITY_BIT-1:0]);
    end

    always_comb begin
        n_link_value = r_link_value;
        n_link_idle  = r_link_idle;
        if (r_in_rx_present) begin
            n_link_idle = 8'd0;
            if (r_in_rx_good) begin
                n_link_value = r_in_rx_byte;
            end
        end else begin
            n_link_idle = link_idle_inc;
            if (link_idle_inc == r_cfg_link_timeout) begin
                n_link_idle  = 8'd0;
                n_link_value = LINK_TIMED_OUT;
            end
        end
    end

    assign day_period = PERIOD_W'(n_link_value[5:0]) * PERIOD_W'(r_cfg_day_gain) + DAY_OFFSET;

    always_comb begin
        n_startup_cnt = r_startup_cnt;
        n_applied     = r_applied;
        n_period      = r_period;
        n_changed     = 1'b0;
        if (r_startup_cnt == r_cfg_startup_delay) begin
            if (r_applied != n_link_value) begin
                n_applied = n_link_value;
                n_changed = 1'b1;
                if (n_link_value[DAY_MODE_BIT]) begin
                    n_period = day_period;
                end else begin
                    n_period = PERIOD_W'(n_link_value[5:0]);
                end
            end
        end else begin
            n_startup_cnt = r_startup_cnt + PERIOD_W'(1);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_debounce      <= RST_DEBOUNCE_COUNT;
            r_cfg_heat_on       <= RST_HEAT_ON;
            r_cfg_heat_off      <= RST_HEAT_OFF;
            r_cfg_day_gain      <= RST_DAY_GAIN;
            r_cfg_link_timeout  <= RST_LINK_TIMEOUT;
            r_cfg_startup_delay <= RST_STARTUP_DELAY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE_COUNT:     r_cfg_debounce      <= i_cfg_data[7:0];
                CFG_HEAT_ON_THRESHOLD:  r_cfg_heat_on       <= i_cfg_data[7:0];
                CFG_HEAT_OFF_THRESHOLD: r_cfg_heat_off      <= i_cfg_data[7:0];
                CFG_DAY_GAIN:           r_cfg_day_gain      <= i_cfg_data[7:0];
                CFG_LINK_TIMEOUT:       r_cfg_link_timeout  <= i_cfg_data[7:0];
                CFG_STARTUP_DELAY:      r_cfg_startup_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_pins       <= i_button_pins;
            r_in_hok        <= i_heater_ok;
            r_in_sample     <= i_adc_sample;
            r_in_rx_present <= i_rx_present;
            r_in_rx_byte    <= i_rx_byte;
            r_in_rx_good    <= i_rx_good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_cand     <= '0;
            r_btn_run      <= '0;
            r_btn_latched  <= '0;
            r_temp_cand    <= '0;
            r_temp_run     <= '0;
            r_temp_latched <= '0;
            r_heat_off     <= 1'b0;
            r_link_value   <= '0;
            r_link_idle    <= '0;
            r_applied      <= '0;
            r_startup_cnt  <= '0;
            r_period       <= '0;
            r_out_valid    <= 1'b0;
        end else if (process) begin
            r_btn_cand     <= n_btn_cand;
            r_btn_run      <= n_btn_run;
            r_btn_latched  <= n_btn_latched;
            r_temp_cand    <= n_temp_cand;
            r_temp_run     <= n_temp_run;
            r_temp_latched <= n_temp_latched;
            r_heat_off     <= n_heat_off;
            r_link_value   <= n_link_value;
            r_link_idle    <= n_link_idle;
            r_applied      <= n_applied;
            r_startup_cnt  <= n_startup_cnt;
            r_period       <= n_period;
            r_out_valid    <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_frame   <= n_frame;
            r_out_changed <= n_changed;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status_frame   = r_out_frame;
    assign o_pwm_period     = r_period;
    assign o_period_changed = r_out_changed;

endmodule

>>> hdl/psfb_checker.sv
// ----------------------------------------------------------------------------
// psfb_checker
// Port-level checks on the result channel of the status frame builder.
// ----------------------------------------------------------------------------
`include "panel_status_frame_builder_defines.svh"

module psfb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [psfb_pkg::FRAME_BITS-1:0] o_status_frame,
    input logic [psfb_pkg::PERIOD_W-1:0]   o_pwm_period,
    input logic                            o_period_changed
);
    import psfb_pkg::*;

    // a held result keeps its payload
    `PSFB_ASSERT_NEXT(a_result_hold, o_valid && i_stall, o_valid && $stable(o_status_frame) && $stable(o_pwm_period) && $stable(o_period_changed), "result changed while stalled")

    // total count of ones is odd
    `PSFB_ASSERT_IMPL(a_frame_parity, o_valid, ^o_status_frame, "frame parity is not odd")

    `PSFB_ASSERT_IMPL(a_frame_fixed, o_valid, (o_status_frame & FRAME_FIXED_MASK) == FRAME_FIXED_VALUE, "frame fixed bits wrong")

endmodule

bind panel_status_frame_builder psfb_checker u_psfb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status_frame   (o_status_frame),
    .o_pwm_period     (o_pwm_period),
    .o_period_changed (o_period_changed)
);
